// ===== design/rdc_pkg.sv =====
// Shared constants and helper functions for the radix digit converter.
package rdc_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int RADIX_W       = 6;
   localparam int CHAR_W        = 8;
   localparam int STEP_BITS     = 8;
   localparam int STEPS         = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int WORK_W        = STEPS * STEP_BITS;
   localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int CNT_W         = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_W         = $clog2(VALUE_WIDTH);
   localparam int REQ_DATA_W    = ((VALUE_WIDTH + 7) / 8) * 8;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0] DEC_DIGITS  = RADIX_W'(10);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO   = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0]  CHAR_A      = CHAR_W'(8'h41);

   // Clamps a written radix into the supported range of bases.
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] raw);
      logic [RADIX_W-1:0] res;
      if (raw < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (raw > RADIX_MAX) begin
         res = RADIX_MAX;
      end else begin
         res = raw;
      end
      return res;
   endfunction

   // Maps a digit value to its ASCII character, '0'-'9' then 'A'-'Z'.
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DEC_DIGITS) begin
         res = CHAR_ZERO + CHAR_W'(d);
      end else begin
         res = CHAR_A + CHAR_W'(d - DEC_DIGITS);
      end
      return res;
   endfunction

endpackage

// ===== design/radix_digit_converter_top.sv =====
// Converts an unsigned value to ASCII digits in a configurable base, one digit per beat.
//
//   Channel  Direction  Payload                          Handshake
//   req_     in         tdata[31:0] value                tvalid / tready
//   rsp_     out        tdata[7:0] digit_char, tlast     tvalid / tready
//   csr_     in         data[5:0] radix                  valid / ready
//
// Each digit is found by one shared restoring divider that retires 8 quotient bits a
// cycle; the input is taken, all digits of the item are divided out and stored, and
// then each digit is read from the digit store and presented as a beat, MSB first.
// Reset is synchronous and restores base ten; the digit store needs no clearing.
// The input is not ready from acceptance until the final digit's beat is taken;
// a stall on the output simply holds the current beat.
module radix_digit_converter_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rdc_pkg::REQ_DATA_W-1:0]       req_tdata,   // [31:0] value
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rdc_pkg::CHAR_W-1:0]           rsp_tdata,   // [7:0] digit_char
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rdc_pkg::RADIX_W-1:0]          csr_data     // [5:0] radix
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_SEND
   } state_type;

   state_type                          state_ff, state_in;
   logic [rdc_pkg::RADIX_W-1:0]        radix_ff, radix_in;
   logic [rdc_pkg::WORK_W-1:0]         work_ff, work_in;
   logic [rdc_pkg::RADIX_W-1:0]        rem_ff, rem_in;
   logic [rdc_pkg::STEP_W-1:0]         step_ff, step_in;
   logic [rdc_pkg::CNT_W-1:0]          count_ff, count_in;
   logic [rdc_pkg::IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [rdc_pkg::RADIX_W-1:0]        rd_data_ff;

   logic [rdc_pkg::RADIX_W-1:0]        digit_store [rdc_pkg::VALUE_WIDTH];
   logic                               mem_we;

   // Outputs of one pass through the shared divider.
   logic [rdc_pkg::WORK_W-1:0]         div_work;
   logic [rdc_pkg::RADIX_W-1:0]        div_rem;

   always_comb begin
      logic [rdc_pkg::WORK_W-1:0]      shift;
      logic [rdc_pkg::RADIX_W-1:0]     r;
      logic [rdc_pkg::RADIX_W:0]       trial;
      logic [rdc_pkg::STEP_BITS-1:0]   q;
      shift = work_ff;
      r     = rem_ff;
      q     = '0;
      for (int i = 0; i < rdc_pkg::STEP_BITS; i++) begin
         trial = {r, shift[rdc_pkg::WORK_W-1]};
         shift = shift << 1;
         if (trial >= {1'b0, radix_ff}) begin
            q[rdc_pkg::STEP_BITS-1-i] = 1'b1;
            r = rdc_pkg::RADIX_W'(trial - {1'b0, radix_ff});
         end else begin
            r = trial[rdc_pkg::RADIX_W-1:0];
         end
      end
      div_work = shift | rdc_pkg::WORK_W'(q);
      div_rem  = r;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tdata  = rdc_pkg::digit_to_ascii(rd_data_ff);
   assign rsp_tlast  = (rd_idx_ff == '0);

   always_comb begin
      state_in  = state_ff;
      radix_in  = radix_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      mem_we    = 1'b0;

      if (csr_valid) begin
         radix_in = rdc_pkg::clamp_radix(csr_data);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               work_in  = rdc_pkg::WORK_W'(req_tdata[rdc_pkg::VALUE_WIDTH-1:0]);
               rem_in   = '0;
               step_in  = '0;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            work_in = div_work;
            if (step_ff == rdc_pkg::STEP_W'(rdc_pkg::STEPS - 1)) begin
               // The remainder is complete: store it as the next digit.
               mem_we   = 1'b1;
               rem_in   = '0;
               step_in  = '0;
               count_in = count_ff + rdc_pkg::CNT_W'(1);
               if (div_work == '0) begin
                  rd_idx_in = count_ff[rdc_pkg::IDX_W-1:0];
                  state_in  = ST_READ;
               end
            end else begin
               rem_in  = div_rem;
               step_in = step_ff + rdc_pkg::STEP_W'(1);
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (rd_idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - rdc_pkg::IDX_W'(1);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         radix_ff  <= rdc_pkg::RADIX_RESET;
         work_ff   <= '0;
         rem_ff    <= '0;
         step_ff   <= '0;
         count_ff  <= '0;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         radix_ff  <= radix_in;
         work_ff   <= work_in;
         rem_ff    <= rem_in;
         step_ff   <= step_in;
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_store[count_ff[rdc_pkg::IDX_W-1:0]] <= div_rem;
      end
      rd_data_ff <= digit_store[rd_idx_ff];
   end

endmodule

// ===== tb/sv/radix_digit_converter_top_tb.sv =====
// Self-checking testbench for the radix digit converter: directed table, then random phases.
module radix_digit_converter_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASES        = 14;
   localparam int PHASE_ITEMS   = 25;

   typedef struct packed {
      logic [rdc_pkg::CHAR_W-1:0] digit_char;
      logic                       last;
   } digit_beat_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rdc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rdc_pkg::CHAR_W-1:0]     rsp_tdata;
   logic                           rsp_tlast;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [rdc_pkg::RADIX_W-1:0]    csr_data = '0;

   digit_beat_type              pending_digits[$];
   logic [rdc_pkg::RADIX_W-1:0] radix_reg = rdc_pkg::RADIX_RESET;
   int                          err_count = 0;
   int                          quiet_cycles = 0;
   int                          send_idle_pct = 0;
   int                          recv_stall_pct = 0;
   int                          hold_seq = 0;

   logic [rdc_pkg::RADIX_W-1:0] row_radix[$];
   logic [31:0]                 row_value[$];
   string                       row_text[$];

   radix_digit_converter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] eff_base(input logic [rdc_pkg::RADIX_W-1:0] r);
      logic [31:0] b;
      if (r < 2) begin
         b = 2;
      end else if (r > 36) begin
         b = 36;
      end else begin
         b = 32'(r);
      end
      return b;
   endfunction

   // Divides repeatedly and queues the digits most significant first.
   function automatic void predict_digits(input logic [31:0] v,
                                          input logic [rdc_pkg::RADIX_W-1:0] r);
      logic [31:0]    base;
      logic [31:0]    quot;
      logic [31:0]    rem [32];
      int             n;
      digit_beat_type beat;
      base = eff_base(r);
      if (v == 0) begin
         beat.digit_char = rdc_pkg::CHAR_ZERO;
         beat.last = 1'b1;
         pending_digits.push_back(beat);
         return;
      end
      quot = v;
      n = 0;
      while (quot != 0 && n < 32) begin
         rem[n] = quot % base;
         quot = quot / base;
         n++;
      end
      for (int k = n - 1; k >= 0; k--) begin
         if (rem[k] < 10) begin
            beat.digit_char = rdc_pkg::CHAR_ZERO + rdc_pkg::CHAR_W'(rem[k]);
         end else begin
            beat.digit_char = rdc_pkg::CHAR_A + rdc_pkg::CHAR_W'(rem[k] - 10);
         end
         beat.last = (k == 0);
         pending_digits.push_back(beat);
      end
   endfunction

   function automatic logic [31:0] pick_value(input logic [rdc_pkg::RADIX_W-1:0] r);
      logic [63:0] power;
      logic [31:0] base;
      int          steps;
      base = eff_base(r);
      case ($urandom_range(9))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'($urandom_range(255));
         3, 4: begin
            // Values at a power of the base and just below it change the digit count.
            power = 64'd1;
            steps = $urandom_range(1, 32);
            while (steps > 0 && power * base <= 64'hFFFF_FFFF) begin
               power = power * base;
               steps--;
            end
            return 32'(power - 64'($urandom_range(1)));
         end
         5: return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_row(input logic [rdc_pkg::RADIX_W-1:0] r, input logic [31:0] v,
                          input string t);
      row_radix.push_back(r);
      row_value.push_back(v);
      row_text.push_back(t);
   endtask

   // Queues the expected digits, then offers the value until it is taken.
   // The valid is left high so that a following item can go out back to back.
   task automatic send_value(input logic [31:0] v, input string text);
      digit_beat_type beat;
      if (text.len() == 0) begin
         predict_digits(v, radix_reg);
      end else begin
         for (int i = 0; i < text.len(); i++) begin
            beat.digit_char = text[i];
            beat.last = (i == text.len() - 1);
            pending_digits.push_back(beat);
         end
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= rdc_pkg::REQ_DATA_W'(v);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops the input valid and waits until every expected digit has come.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_radix(input logic [rdc_pkg::RADIX_W-1:0] r);
      csr_valid <= 1'b1;
      csr_data <= r;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      radix_reg = r;
      @(posedge clock);
   endtask

   initial begin : rsp_sink
      int hold_seen;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            $error("unexpected beat: digit_char %h, last %b", rsp_tdata, rsp_tlast);
            err_count = err_count + 1;
         end else begin
            if (rsp_tdata !== pending_digits[0].digit_char) begin
               $error("digit_char: expected %h, actual %h",
                      pending_digits[0].digit_char, rsp_tdata);
               err_count = err_count + 1;
            end
            if (rsp_tlast !== pending_digits[0].last) begin
               $error("last: expected %b, actual %b", pending_digits[0].last, rsp_tlast);
               err_count = err_count + 1;
            end
            void'(pending_digits.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [rdc_pkg::RADIX_W-1:0] r;
      int                          n;

      // Rows with a string carry their digits typed in; the rest go to the predictor.
      add_row(10, 32'h0, "0");
      add_row(10, 32'hFFFF_FFFF, "4294967295");
      add_row(10, 32'd9, "9");
      add_row(10, 32'd10, "10");
      add_row(10, 32'd1234567, "");
      add_row(2, 32'h0, "0");
      add_row(2, 32'h1, "1");
      add_row(2, 32'hFFFF_FFFF, "11111111111111111111111111111111");
      add_row(2, 32'h8000_0000, "10000000000000000000000000000000");
      add_row(2, 32'hAAAA_AAAA, "");
      add_row(36, 32'd35, "Z");
      add_row(36, 32'd36, "10");
      add_row(36, 32'hFFFF_FFFF, "1Z141Z3");
      add_row(16, 32'hFFFF_FFFF, "FFFFFFFF");
      add_row(16, 32'hDEAD_BEEF, "DEADBEEF");
      add_row(16, 32'h0, "0");
      // Radix values outside two to thirty-six saturate to the nearest end.
      add_row(0, 32'd5, "101");
      add_row(1, 32'd6, "110");
      add_row(63, 32'd35, "Z");
      add_row(37, 32'd71, "1Z");
      add_row(8, 32'hFFFF_FFFF, "37777777777");
      add_row(3, 32'd12345678, "");

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < row_value.size(); i++) begin
         if (row_radix[i] != radix_reg) begin
            drain_block();
            write_radix(row_radix[i]);
         end
         send_value(row_value[i], row_text[i]);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_block();
         case (p)
            0: r = 10;
            1: r = 2;
            2: r = 36;
            3: r = 0;
            4: r = 63;
            5: r = 16;
            default: r = rdc_pkg::RADIX_W'($urandom_range(63));
         endcase
         write_radix(r);
         case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 21; recv_stall_pct = 21; end
         endcase
         // A long output stall while items keep coming fills the block.
         if (p == 4 || p == 9) hold_seq = hold_seq + 1;
         n = PHASE_ITEMS;
         for (int i = 0; i < n; i++) begin
            send_value(pick_value(radix_reg), "");
            if (p == 6 && i == PHASE_ITEMS / 2) drain_block();
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain_block();
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rdc_pkg.sv
design/radix_digit_converter_top.sv
tb/sv/radix_digit_converter_top_tb.sv
